[rtl/rhp_pkg.sv]
package rhp_pkg;

   // Result status codes
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_SHORT_HEADER  = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION   = 3'd2;
   localparam logic [2:0] STATUS_SHORT_CSRC    = 3'd3;
   localparam logic [2:0] STATUS_SHORT_EXT_HDR = 3'd4;
   localparam logic [2:0] STATUS_SHORT_EXT     = 3'd5;

   // Fixed header layout
   localparam logic [15:0] FIXED_HDR_BYTES = 16'd12;
   localparam logic [1:0]  RTP_VERSION     = 2'b10;
   localparam logic [15:0] SEQ_HALF_WINDOW = 16'h8000;

   // Request item: one packet byte
   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       last_byte;
   } req_type;

   // Result item: one per packet
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic [15:0] seq_number;
      logic [47:0] srtp_index;
   } rsp_type;

   // Parsed packet summary handed from the parser to the index stage
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic [15:0] seq_number;
   } hdr_type;

endpackage

[rtl/rtp_header_parse_srtp_index.sv]
// RTP header parser with SRTP packet index estimation. Packet bytes enter one
// per cycle on req_data, the final byte flagged by last_byte; a byte is taken
// every cycle that req_stall is low, with no gap needed between packets. The
// last byte yields one result on rsp_data via the queue and result register:
// status, payload offset and length, sequence number and the 48-bit index
// (offset, length and index read zero unless status is ok). The parser and
// the index stage are split by a two-entry summary queue; req_stall rises
// only when that queue fills because results are held back by rsp_stall.
// The index stage keeps the highest index seen; zero there means unseeded.
module rtp_header_parse_srtp_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  rhp_pkg::req_type  req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   output rhp_pkg::rsp_type  rsp_data,
   input  logic              rsp_stall
);
   import rhp_pkg::*;

   logic    push;
   hdr_type push_data;
   logic    pop;
   logic    queue_full;
   logic    head_valid;
   hdr_type head_data;

   rhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_data  (push_data)
   );

   rhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rhp_index u_index (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

[rtl/rhp_front.sv]
module rhp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  rhp_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output rhp_pkg::hdr_type  push_data
);
   import rhp_pkg::*;

   logic [15:0] pos_ff,   pos_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] seq_ff,   seq_in;
   logic [15:0] extw_ff,  extw_in;

   logic        accept;
   logic [6:0]  ext_at;
   logic [15:0] len;
   logic [3:0]  cc;
   logic [15:0] off_base;
   logic [15:0] off_ext_hdr;
   logic [18:0] off_full;
   logic [2:0]  status;
   logic [15:0] poff;

   // Hold off bytes while the queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & req_data.last_byte;

   // Capture header fields from the current byte
   assign ext_at = 7'd14 + {1'b0, first_ff[3:0], 2'b00};

   always_comb begin
      first_in = first_ff;
      seq_in   = seq_ff;
      extw_in  = extw_ff;
      if (pos_ff == 16'd0) begin
         first_in = req_data.pkt_byte;
      end else if (pos_ff == 16'd2) begin
         seq_in = {req_data.pkt_byte, seq_ff[7:0]};
      end else if (pos_ff == 16'd3) begin
         seq_in = {seq_ff[15:8], req_data.pkt_byte};
      end
      if (pos_ff >= FIXED_HDR_BYTES && pos_ff == {9'd0, ext_at}) begin
         extw_in = {req_data.pkt_byte, extw_ff[7:0]};
      end else if (pos_ff >= FIXED_HDR_BYTES && pos_ff == {9'd0, ext_at} + 16'd1) begin
         extw_in = {extw_ff[15:8], req_data.pkt_byte};
      end
   end

   // Saturate the byte count
   assign pos_in = (pos_ff == 16'hffff) ? pos_ff : pos_ff + 16'd1;
   assign len    = pos_in;

   // Classify the packet on its last byte
   assign cc          = first_in[3:0];
   assign off_base    = FIXED_HDR_BYTES + {10'd0, cc, 2'b00};
   assign off_ext_hdr = off_base + 16'd4;
   assign off_full    = {3'd0, off_ext_hdr} + {1'b0, extw_in, 2'b00};

   always_comb begin
      status = STATUS_OK;
      poff   = off_base;
      if (len < FIXED_HDR_BYTES) begin
         status = STATUS_SHORT_HEADER;
      end else if (first_in[7:6] != RTP_VERSION) begin
         status = STATUS_BAD_VERSION;
      end else if (len < off_base) begin
         status = STATUS_SHORT_CSRC;
      end else if (first_in[4]) begin
         poff = off_full[15:0];
         if (len < off_ext_hdr) begin
            status = STATUS_SHORT_EXT_HDR;
         end else if ({3'd0, len} < off_full) begin
            status = STATUS_SHORT_EXT;
         end
      end
   end

   always_comb begin
      push_data.status         = status;
      push_data.seq_number     = seq_in;
      push_data.payload_offset = (status == STATUS_OK) ? poff : 16'd0;
      push_data.payload_length = (status == STATUS_OK) ? len - poff : 16'd0;
   end

   // Advance per-packet state, clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         first_ff <= '0;
         seq_ff   <= '0;
         extw_ff  <= '0;
      end else if (accept) begin
         if (req_data.last_byte) begin
            pos_ff   <= '0;
            first_ff <= '0;
            seq_ff   <= '0;
            extw_ff  <= '0;
         end else begin
            pos_ff   <= pos_in;
            first_ff <= first_in;
            seq_ff   <= seq_in;
            extw_ff  <= extw_in;
         end
      end
   end

endmodule

[rtl/rhp_queue.sv]
module rhp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rhp_pkg::hdr_type  push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output rhp_pkg::hdr_type  head_data
);
   import rhp_pkg::*;

   hdr_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

[rtl/rhp_index.sv]
module rhp_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  rhp_pkg::hdr_type  head_data,
   output logic              pop,
   output logic              rsp_valid,
   output rhp_pkg::rsp_type  rsp_data,
   input  logic              rsp_stall
);
   import rhp_pkg::*;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [47:0] highest_ff, highest_in;

   logic [47:0] last;
   logic [15:0] seq;
   logic [31:0] epoch;
   logic [16:0] diff;
   logic [47:0] index;

   assign pop       = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Estimate the packet index; upper 32 bits of guess match the last index,
   // so the difference reduces to a 17-bit signed compare on the low half
   assign seq   = head_data.seq_number;
   assign last  = (highest_ff == 48'd0) ? {32'd0, seq} : highest_ff;
   assign epoch = last[47:16];
   assign diff  = {1'b0, seq} - {1'b0, last[15:0]};

   always_comb begin
      index      = {epoch, seq};
      highest_in = highest_ff;
      if (head_data.status == STATUS_OK) begin
         highest_in = last;
         if (!diff[16]) begin
            if (diff[15:0] < SEQ_HALF_WINDOW) begin
               highest_in = index;
            end else if (epoch != 32'd0) begin
               index = {epoch - 32'd1, seq};
            end
         end else if (diff < {1'b1, SEQ_HALF_WINDOW}) begin
            index      = {epoch + 32'd1, seq};
            highest_in = index;
         end
      end else begin
         index = 48'd0;
      end
   end

   // Load the result register and update the stored index
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         highest_ff   <= '0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            highest_ff   <= highest_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff.status         <= head_data.status;
         rsp_ff.payload_offset <= head_data.payload_offset;
         rsp_ff.payload_length <= head_data.payload_length;
         rsp_ff.seq_number     <= head_data.seq_number;
         rsp_ff.srtp_index     <= index;
      end
   end

endmodule

[dv/rtp_header_parse_srtp_index_check.sv]
`timescale 1ns / 1ps

module rtp_header_parse_srtp_index_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  rhp_pkg::req_type req_data,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  rhp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall,
   output int               error_count,
   output int               pending_count,
   output int               result_count
);
   import rhp_pkg::*;

   localparam logic [47:0] ROC_MASK = 48'hffff_ffff_0000;
   localparam logic [47:0] SEQ_SPAN = 48'h1_0000;

   // Per-packet parse state plus the index that survives packets
   logic [15:0] byte_count    = '0;
   logic [7:0]  hdr_byte0     = '0;
   logic [15:0] seq_bytes     = '0;
   logic [15:0] ext_len_words = '0;
   logic [47:0] highest_idx   = '0;

   rsp_type packet_results_q[$];
   int      errors  = 0;
   int      results = 0;

   // Estimate the 48-bit packet index; zero in highest_idx means unseeded
   function automatic logic [47:0] estimate_srtp_index(input logic [15:0] seq);
      logic [47:0] guess;
      logic [47:0] last;
      if (highest_idx == '0) begin
         highest_idx = {32'd0, seq};
      end
      last  = highest_idx;
      guess = (last & ROC_MASK) | {32'd0, seq};
      if (guess >= last) begin
         if (guess - last < {32'd0, SEQ_HALF_WINDOW}) begin
            highest_idx = guess;
         end else if (guess >= SEQ_SPAN) begin
            guess = guess - SEQ_SPAN;
         end
      end else if (last - guess > {32'd0, SEQ_HALF_WINDOW}) begin
         // Sequence number rolled over: advance the rollover count
         guess       = guess + SEQ_SPAN;
         highest_idx = guess;
      end
      return guess;
   endfunction

   // Absorb one packet byte; on the final byte queue the packet summary
   function automatic void take_packet_byte(input req_type r);
      int      pos;
      int      ext_at;
      int      len;
      int      off;
      rsp_type res;
      pos    = int'(byte_count);
      ext_at = int'(FIXED_HDR_BYTES) + 4 * int'(hdr_byte0[3:0]) + 2;
      if (pos == 0) begin
         hdr_byte0 = r.pkt_byte;
      end else if (pos == 2) begin
         seq_bytes[15:8] = r.pkt_byte;
      end else if (pos == 3) begin
         seq_bytes[7:0] = r.pkt_byte;
      end
      if (pos >= int'(FIXED_HDR_BYTES) && pos == ext_at) begin
         ext_len_words[15:8] = r.pkt_byte;
      end else if (pos >= int'(FIXED_HDR_BYTES) && pos == ext_at + 1) begin
         ext_len_words[7:0] = r.pkt_byte;
      end
      // Saturate the byte count
      if (byte_count != 16'hffff) begin
         byte_count = byte_count + 16'd1;
      end
      if (!r.last_byte) begin
         return;
      end

      res            = '0;
      res.seq_number = seq_bytes;
      len            = int'(byte_count);
      off            = int'(FIXED_HDR_BYTES) + 4 * int'(hdr_byte0[3:0]);
      if (len < int'(FIXED_HDR_BYTES)) begin
         res.status = STATUS_SHORT_HEADER;
      end else if (hdr_byte0[7:6] != RTP_VERSION) begin
         res.status = STATUS_BAD_VERSION;
      end else if (len < off) begin
         res.status = STATUS_SHORT_CSRC;
      end else if (hdr_byte0[4] && len - off < 4) begin
         res.status = STATUS_SHORT_EXT_HDR;
      end else begin
         if (hdr_byte0[4]) begin
            off = off + 4 + 4 * int'(ext_len_words);
         end
         if (len < off) begin
            res.status = STATUS_SHORT_EXT;
         end else begin
            res.status         = STATUS_OK;
            res.payload_offset = 16'(off);
            res.payload_length = 16'(len - off);
            res.srtp_index     = estimate_srtp_index(seq_bytes);
         end
      end
      packet_results_q.push_back(res);

      // Clear per-packet state, keep the index
      byte_count    = '0;
      hdr_byte0     = '0;
      seq_bytes     = '0;
      ext_len_words = '0;
   endfunction

   function automatic void check_field(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare results against the oldest prediction, then absorb requests
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         byte_count    = '0;
         hdr_byte0     = '0;
         seq_bytes     = '0;
         ext_len_words = '0;
         highest_idx   = '0;
         packet_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (packet_results_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d seq 0x%0h",
                        $time, rsp_data.status, rsp_data.seq_number);
               errors++;
            end else begin
               want = packet_results_q.pop_front();
               check_field("status", 48'(want.status), 48'(rsp_data.status));
               check_field("payload_offset", 48'(want.payload_offset),
                           48'(rsp_data.payload_offset));
               check_field("payload_length", 48'(want.payload_length),
                           48'(rsp_data.payload_length));
               check_field("seq_number", 48'(want.seq_number), 48'(rsp_data.seq_number));
               check_field("srtp_index", want.srtp_index, rsp_data.srtp_index);
            end
         end
         if (req_valid && !req_stall) begin
            take_packet_byte(req_data);
         end
      end
      error_count   <= errors;
      pending_count <= packet_results_q.size();
      result_count  <= results;
   end

endmodule

[dv/rtp_header_parse_srtp_index_tb.sv]
`timescale 1ns / 1ps

module rtp_header_parse_srtp_index_tb;
   import rhp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_BYTES    = 380;
   localparam int SETTLE_CYCLES  = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   int error_count;
   int pending_count;
   int result_count;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          idle_cycles    = 0;
   int          bytes_sent     = 0;
   int          packets_sent   = 0;
   logic [15:0] prev_seq       = '0;
   logic [7:0]  pkt_q[$];

   always #5 clock = ~clock;

   rtp_header_parse_srtp_index u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   rtp_header_parse_srtp_index_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .rsp_stall     (rsp_stall),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Pick the next sequence number: mostly near the last one, some far jumps
   function automatic logic [15:0] next_seq();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         prev_seq = prev_seq + 16'($urandom_range(1, 16'h300));
      end else if (pick < 70) begin
         prev_seq = prev_seq - 16'($urandom_range(1, 16'h300));
      end else if (pick < 85) begin
         prev_seq = prev_seq + 16'($urandom_range(16'h7000, 16'h9000));
      end else begin
         prev_seq = 16'($urandom);
      end
      return prev_seq;
   endfunction

   // Build one packet: well-formed, truncated, bad version or noise
   function automatic void make_packet();
      int          kind;
      int          cc;
      int          nbody;
      int          cut;
      logic        ext;
      logic [7:0]  b0;
      logic [15:0] seq;
      logic [15:0] ew;
      kind = $urandom_range(99);
      pkt_q.delete();
      if (kind >= 93) begin
         repeat ($urandom_range(1, 20)) pkt_q.push_back(8'($urandom));
         return;
      end
      cc  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
      ext = 1'($urandom);
      b0  = {2'b10, 1'($urandom), ext, 4'(cc)};
      if (kind >= 85) begin
         while (b0[7:6] == RTP_VERSION) b0[7:6] = 2'($urandom);
      end
      seq   = next_seq();
      pkt_q = {b0, 8'($urandom), seq[15:8], seq[7:0]};
      repeat (8 + 4 * cc) pkt_q.push_back(8'($urandom));
      if (ext) begin
         ew = ($urandom_range(19) == 0) ? 16'($urandom_range(4, 16'hffff))
                                        : 16'($urandom_range(3));
         pkt_q.push_back(8'($urandom));
         pkt_q.push_back(8'($urandom));
         pkt_q.push_back(ew[15:8]);
         pkt_q.push_back(ew[7:0]);
         // A huge extension length cannot be sent whole: leave it short
         nbody = (ew > 16'd3) ? $urandom_range(12) : 4 * int'(ew);
         repeat (nbody) pkt_q.push_back(8'($urandom));
      end
      repeat ($urandom_range(10)) pkt_q.push_back(8'($urandom));
      if (kind >= 70 && kind < 85 && pkt_q.size() > 1) begin
         cut = $urandom_range(1, pkt_q.size() - 1);
         while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end
   endfunction

   // Offer one request, with random idle cycles ahead of it; hold until taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data  = req_type'($urandom);
         @(posedge clock);
      end
      @(negedge clock);
      req_valid          = 1'b1;
      req_data.pkt_byte  = b;
      req_data.last_byte = fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
      packets_sent++;
   endtask

   // Hold off the sender until every predicted result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int phase_start;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: lone byte, partial sequence number, minimal header, bad version
      pkt_q = {8'hff};
      send_packet();
      pkt_q = {8'h80, 8'h00, 8'hab};
      send_packet();
      pkt_q = {8'h80, 8'h00, 8'h00, 8'h00};
      repeat (8) pkt_q.push_back(8'h00);
      send_packet();
      pkt_q.delete();
      repeat (12) pkt_q.push_back(8'hff);
      send_packet();
      pkt_q.delete();
      drain_results();

      // Random packets under four idle/stall mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            make_packet();
            send_packet();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d request bytes in %0d packets, directed and random,",
               bytes_sent, packets_sent);
      $display("under four idle/stall mixes; %0d results compared, %0d mismatches, %0d missing.",
               result_count, error_count, pending_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
